>>> sv/wmmf_pkg.sv
// Shared types and constants for the window mean / midrange filter.
// No dependencies; imported by the filter top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package wmmf_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CFG_W      = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned COORD_W    = 11;
  localparam int unsigned SUM3_W     = 10;
  localparam int unsigned SUM5_W     = 11;
  localparam int unsigned SUM_W      = 13;
  localparam int unsigned RECIP_W    = 15;
  localparam int unsigned PROD_W     = SUM_W + RECIP_W;
  localparam int unsigned DIV_SHIFT  = 18;

  // floor(s * RECIP >> DIV_SHIFT) equals s / n for every s below 2**SUM_W
  localparam logic [RECIP_W-1:0] RECIP_9  = 15'd29128;
  localparam logic [RECIP_W-1:0] RECIP_25 = 15'd10486;

  localparam logic [CFG_W-1:0] MIN_DIM      = 12'd5;
  localparam logic [CFG_W-1:0] RST_WIDTH    = 12'd640;
  localparam logic [CFG_W-1:0] RST_HEIGHT   = 12'd480;
  localparam logic [2:0]       WSIZE_3      = 3'd3;
  localparam logic [2:0]       WSIZE_5      = 3'd5;
  localparam logic [PIX_W-1:0] PIX_MAX      = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_MIDRANGE_MODE = 2'd2,
    REG_WINDOW_SIZE   = 2'd3
  } cfg_reg_e;

  // sum, minimum and maximum of one window column, over 3 and over 5 rows
  typedef struct packed {
    logic [SUM3_W-1:0] sum3;
    logic [PIX_W-1:0]  lo3;
    logic [PIX_W-1:0]  hi3;
    logic [SUM5_W-1:0] sum5;
    logic [PIX_W-1:0]  lo5;
    logic [PIX_W-1:0]  hi5;
  } col_agg_t;

  // result tag that travels with a word down the pipeline
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } res_tag_t;

endpackage

`default_nettype wire

>>> sv/wmmf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module wmmf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> sv/window_mean_midrange_filter.sv
// Streaming 3x3 / 5x5 window mean or midrange filter, top level.
// Depends on wmmf_pkg and wmmf_ram (line store).
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_ready_o   pixel_i, frame_start_i
//   out      source     out_valid_o / out_ready_i filtered_o, center_row_o,
//                                                 center_col_o, frame_last_o
//   cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One pixel per clock unless a waiting result stalls the pipeline; each word is registered at every stage below.
// Stages: line store read, column reduce and write back, window reduce,
// divide or midrange into the output register.
// The whole pipeline moves when the output register is empty or being taken,
// so in_ready_o follows out_ready_i while a word waits. cfg is always ready.
// Reset clears position and valid bits; line store holds garbage until written.
`timescale 1ns / 1ps
`default_nettype none

module window_mean_midrange_filter
  import wmmf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048,
  parameter int unsigned MAX_WINDOW = 5
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [PIX_W-1:0]     pixel_i,
  input  wire logic                 frame_start_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [PIX_W-1:0]     filtered_o,
  output logic      [COORD_W-1:0]   center_row_o,
  output logic      [COORD_W-1:0]   center_col_o,
  output logic                      frame_last_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned LINES = MAX_WINDOW - 1;
  localparam int unsigned LW    = LINES * PIX_W;

  // configuration
  logic [CFG_W-1:0] frame_width_q, frame_height_q;
  logic             midrange_mode_q;
  logic [2:0]       window_size_q;

  // position of the next pixel
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  // pipeline
  logic            adv, accept;
  logic            s1_v_q, s1_emit_q, s1_fwd_q;
  logic [CW-1:0]   s1_addr_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [LW-1:0]   s1_fwd_data_q;
  res_tag_t        s1_tag_q, s2_tag_q, s3_tag_q, out_tag_q;
  logic            s2_v_q, s3_v_q, out_v_q;
  logic [SUM_W-1:0] s3_sum_q, s3_sum_d;
  logic [PIX_W-1:0] s3_lo_q, s3_lo_d, s3_hi_q, s3_hi_d;
  logic [PIX_W-1:0] out_pix_q, out_pix_d;
  col_agg_t        win_col_q [MAX_WINDOW];
  col_agg_t        col_new;

  logic [LW-1:0]   ram_rdata, lines, wdata;

  // stage 0 signals
  logic [CW:0]     w_lim;
  logic [RW:0]     h_lim;
  logic [CW-1:0]   c0;
  logic [RW-1:0]   r0;
  logic            ws3, ws5, emit0, last0, fwd0;
  logic [2:0]      edge_lo;
  res_tag_t        tag0;

  assign adv         = !out_v_q || out_ready_i;
  assign in_ready_o  = adv;
  assign accept      = in_valid_i && adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q   <= RST_WIDTH;
      frame_height_q  <= RST_HEIGHT;
      midrange_mode_q <= 1'b0;
      window_size_q   <= WSIZE_3;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:   frame_width_q   <= cfg_data_i;
        REG_FRAME_HEIGHT:  frame_height_q  <= cfg_data_i;
        REG_MIDRANGE_MODE: midrange_mode_q <= cfg_data_i[0];
        REG_WINDOW_SIZE:   window_size_q   <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // clamp frame size to [5, max]
  always_comb begin
    if (frame_width_q < MIN_DIM) begin
      w_lim = (CW + 1)'(MIN_DIM);
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      w_lim = (CW + 1)'(MAX_WIDTH);
    end else begin
      w_lim = (CW + 1)'(frame_width_q);
    end
    if (frame_height_q < MIN_DIM) begin
      h_lim = (RW + 1)'(MIN_DIM);
    end else if (32'(frame_height_q) > MAX_HEIGHT) begin
      h_lim = (RW + 1)'(MAX_HEIGHT);
    end else begin
      h_lim = (RW + 1)'(frame_height_q);
    end
  end

  assign ws3     = (window_size_q == WSIZE_3);
  assign ws5     = (window_size_q == WSIZE_5) && (MAX_WINDOW >= 5);
  assign edge_lo = ws5 ? 3'd4 : 3'd2;

  always_comb begin
    c0 = frame_start_i ? '0 : col_q;
    r0 = frame_start_i ? '0 : row_q;
    emit0 = (ws3 || ws5) && ({1'b0, r0} < h_lim) && ({1'b0, c0} < w_lim)
            && (32'(r0) >= 32'(edge_lo)) && (32'(c0) >= 32'(edge_lo));
    last0 = ({1'b0, r0} == h_lim - 1'b1) && ({1'b0, c0} == w_lim - 1'b1);
    tag0.row  = COORD_W'(r0 - RW'(edge_lo >> 1));
    tag0.col  = COORD_W'(c0 - CW'(edge_lo >> 1));
    tag0.last = last0;
    // raster advance
    if ({1'b0, c0} + 1'b1 >= w_lim) begin
      col_d = '0;
      if ({1'b0, r0} + 1'b1 >= h_lim) begin
        row_d = '0;
      end else begin
        row_d = r0 + 1'b1;
      end
    end else begin
      col_d = c0 + 1'b1;
      row_d = r0;
    end
  end

  // the word written back this cycle may be the one being read
  assign fwd0 = s1_v_q && (s1_addr_q == c0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      s1_v_q  <= accept;
      s2_v_q  <= s1_v_q && s1_emit_q;
      s3_v_q  <= s2_v_q;
      out_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_emit_q     <= emit0;
      s1_fwd_q      <= fwd0;
      s1_fwd_data_q <= wdata;
      s1_addr_q     <= c0;
      s1_pix_q      <= pixel_i;
      s1_tag_q      <= tag0;
      s2_tag_q      <= s1_tag_q;
      s3_tag_q      <= s2_tag_q;
      s3_sum_q      <= s3_sum_d;
      s3_lo_q       <= s3_lo_d;
      s3_hi_q       <= s3_hi_d;
      out_tag_q     <= s3_tag_q;
      out_pix_q     <= out_pix_d;
      if (s1_v_q) begin
        for (int i = 0; i < MAX_WINDOW - 1; i++) begin
          win_col_q[i] <= win_col_q[i + 1];
        end
        win_col_q[MAX_WINDOW-1] <= col_new;
      end
    end
  end

  wmmf_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_v_q && adv),
    .waddr_i (s1_addr_q),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (c0),
    .rdata_o (ram_rdata)
  );

  // stage 1: new column, write back the shifted lines, reduce the column
  assign lines = s1_fwd_q ? s1_fwd_data_q : ram_rdata;

  always_comb begin
    logic [PIX_W-1:0] p [5];
    for (int k = 0; k < 5; k++) begin
      p[k] = '0;
    end
    p[0] = s1_pix_q;
    for (int k = 0; k < LINES; k++) begin
      p[k + 1] = lines[k*PIX_W +: PIX_W];
    end
    wdata[PIX_W-1:0] = s1_pix_q;
    for (int k = 1; k < LINES; k++) begin
      wdata[k*PIX_W +: PIX_W] = lines[(k-1)*PIX_W +: PIX_W];
    end
    col_new.sum3 = SUM3_W'(p[0]) + SUM3_W'(p[1]) + SUM3_W'(p[2]);
    col_new.sum5 = SUM5_W'(col_new.sum3) + SUM5_W'(p[3]) + SUM5_W'(p[4]);
    col_new.lo3  = p[0];
    col_new.hi3  = p[0];
    for (int k = 1; k < 3; k++) begin
      if (p[k] < col_new.lo3) col_new.lo3 = p[k];
      if (p[k] > col_new.hi3) col_new.hi3 = p[k];
    end
    col_new.lo5 = col_new.lo3;
    col_new.hi5 = col_new.hi3;
    for (int k = 3; k < 5; k++) begin
      if (p[k] < col_new.lo5) col_new.lo5 = p[k];
      if (p[k] > col_new.hi5) col_new.hi5 = p[k];
    end
  end

  // stage 2: reduce the newest 3 or 5 columns
  always_comb begin
    s3_sum_d = '0;
    s3_lo_d  = PIX_MAX;
    s3_hi_d  = '0;
    for (int j = 0; j < MAX_WINDOW; j++) begin
      if (ws5) begin
        s3_sum_d = s3_sum_d + SUM_W'(win_col_q[MAX_WINDOW-1-j].sum5);
        if (win_col_q[MAX_WINDOW-1-j].lo5 < s3_lo_d) s3_lo_d = win_col_q[MAX_WINDOW-1-j].lo5;
        if (win_col_q[MAX_WINDOW-1-j].hi5 > s3_hi_d) s3_hi_d = win_col_q[MAX_WINDOW-1-j].hi5;
      end else if (j < 3) begin
        s3_sum_d = s3_sum_d + SUM_W'(win_col_q[MAX_WINDOW-1-j].sum3);
        if (win_col_q[MAX_WINDOW-1-j].lo3 < s3_lo_d) s3_lo_d = win_col_q[MAX_WINDOW-1-j].lo3;
        if (win_col_q[MAX_WINDOW-1-j].hi3 > s3_hi_d) s3_hi_d = win_col_q[MAX_WINDOW-1-j].hi3;
      end
    end
  end

  // stage 3: divide by 9 or 25 through the reciprocal, or midrange
  always_comb begin
    logic [PROD_W-1:0] prod;
    logic [PIX_W-1:0]  span;
    prod = PROD_W'(s3_sum_q) * PROD_W'(ws5 ? RECIP_25 : RECIP_9);
    span = s3_hi_q - s3_lo_q;
    if (midrange_mode_q) begin
      out_pix_d = (span >> 1) + s3_lo_q;
    end else begin
      out_pix_d = prod[DIV_SHIFT +: PIX_W];
    end
  end

  assign out_valid_o  = out_v_q;
  assign filtered_o   = out_pix_q;
  assign center_row_o = out_tag_q.row;
  assign center_col_o = out_tag_q.col;
  assign frame_last_o = out_tag_q.last;

endmodule

`default_nettype wire

>>> sv/wmmf_checker.sv
// Port-level checks for window_mean_midrange_filter, bound to the top level.
// Depends on wmmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wmmf_checker
  import wmmf_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_ready_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire logic [PIX_W-1:0]     filtered_o,
  input wire logic [COORD_W-1:0]   center_row_o,
  input wire logic [COORD_W-1:0]   center_col_o,
  input wire logic                 frame_last_o,
  input wire logic                 cfg_ready_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(filtered_o)
      && $stable(center_row_o) && $stable(center_col_o) && $stable(frame_last_o))
    else $error("result word changed under stall");

  // input side never blocks while the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input stalled with free output");

  // input side stalls exactly when a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

  // window center never lies on the top row or the left column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> center_row_o != '0 && center_col_o != '0)
    else $error("result centered on border");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind window_mean_midrange_filter wmmf_checker u_wmmf_checker (.*);

`default_nettype wire

>>> test/tb.sv
// Self-checking bench for window_mean_midrange_filter: a directed frame, then random frames.
// Depends on wmmf_pkg and the filter RTL; a behavioral window filter predicts every untyped word.
`timescale 1ns / 1ps

module tb;
  import wmmf_pkg::*;

  localparam int unsigned MAX_DIM     = 2048;
  localparam int unsigned WIN         = 5;
  localparam int unsigned PIPE_SETTLE = 8;       // pipeline is 4 deep
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam logic [2:0]  WSIZE_BAD   = 3'd4;
  localparam logic        MODE_MEAN   = 1'b0;
  localparam logic        MODE_MID    = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0]   filtered;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } out_word_t;

  typedef enum logic {ROW_CFG, ROW_PIXEL} row_kind_e;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct {
    row_kind_e        kind;
    cfg_reg_e         idx;
    logic [CFG_W-1:0] data;
    logic [PIX_W-1:0] pix;
    logic             fs;
    bit               typed;
    out_word_t        word;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [PIX_W-1:0]     pixel_i = '0;
  logic                 frame_start_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [PIX_W-1:0]     filtered_o;
  logic [COORD_W-1:0]   center_row_o;
  logic [COORD_W-1:0]   center_col_o;
  logic                 frame_last_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  // predictor state
  logic [PIX_W-1:0] line_mem [WIN-1][MAX_DIM];
  logic [PIX_W-1:0] win_regs [WIN][WIN];
  int unsigned      row_pos;
  int unsigned      col_pos;
  logic [CFG_W-1:0] frame_width_q;
  logic [CFG_W-1:0] frame_height_q;
  logic             midrange_q;
  logic [2:0]       wsize_q;

  out_word_t   pending_words [$];
  stim_row_t   stim_rows [$];
  out_word_t   got;
  out_word_t   want;
  int unsigned bad_words = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  bit          need_restart = 1'b0;

  window_mean_midrange_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .filtered_o    (filtered_o),
    .center_row_o  (center_row_o),
    .center_col_o  (center_col_o),
    .frame_last_o  (frame_last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // one pixel through the line stores and window; returns 1 when a word comes out
  function automatic bit window_filter_step(input logic [PIX_W-1:0] pix, input logic fs,
                                            output out_word_t word);
    int unsigned      w, h, r, c, ws, half, sum, lo, hi, v, first, res;
    logic [PIX_W-1:0] column [WIN];
    bit               hit;
    w = clamp_dim(frame_width_q);
    h = clamp_dim(frame_height_q);
    word = '0;
    hit = 1'b0;
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = (col_pos >= MAX_DIM) ? MAX_DIM - 1 : col_pos;
    // oldest row on top, new pixel at the bottom
    column[WIN-1] = pix;
    for (int k = 0; k < WIN - 1; k++) column[WIN-2-k] = line_mem[k][c];
    for (int k = WIN - 2; k > 0; k--) line_mem[k][c] = line_mem[k-1][c];
    line_mem[0][c] = pix;
    for (int i = 0; i < WIN; i++) begin
      for (int j = 0; j < WIN - 1; j++) win_regs[i][j] = win_regs[i][j+1];
      win_regs[i][WIN-1] = column[i];
    end
    ws = wsize_q;
    half = ws / 2;
    if ((ws == WSIZE_3 || ws == WSIZE_5) && r < h && c < w && r >= 2 * half &&
        c >= 2 * half) begin
      sum = 0;
      lo = PIX_MAX;
      hi = 0;
      first = WIN - ws;
      for (int i = first; i < WIN; i++) begin
        for (int j = first; j < WIN; j++) begin
          v = win_regs[i][j];
          sum += v;
          if (v < lo) lo = v;
          if (v > hi) hi = v;
        end
      end
      res = (midrange_q == MODE_MID) ? ((hi - lo) >> 1) + lo : sum / (ws * ws);
      word.filtered = res[PIX_W-1:0];
      word.row = COORD_W'(r - half);
      word.col = COORD_W'(c - half);
      word.last = (r == h - 1 && c == w - 1);
      hit = 1'b1;
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    return hit;
  endfunction

  function automatic void add_cfg(input cfg_reg_e idx, input logic [CFG_W-1:0] data);
    stim_row_t row;
    row = '{kind: ROW_CFG, idx: idx, data: data, pix: '0, fs: 1'b0, typed: 1'b0, word: '0};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_px(input logic [PIX_W-1:0] pix, input logic fs);
    stim_row_t row;
    row = '{kind: ROW_PIXEL, idx: REG_FRAME_WIDTH, data: '0, pix: pix, fs: fs, typed: 1'b0,
            word: '0};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_px_typed(input logic [PIX_W-1:0] pix, input logic fs,
                                       input logic [PIX_W-1:0] filt,
                                       input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c,
                                       input logic last);
    stim_row_t row;
    row = '{kind: ROW_PIXEL, idx: REG_FRAME_WIDTH, data: '0, pix: pix, fs: fs, typed: 1'b1,
            word: {filt, r, c, last}};
    stim_rows.push_back(row);
  endfunction

  task automatic note_bad_word(input string what, input out_word_t exp_w, input out_word_t act_w);
    string exp_s;
    string act_s;
    bad_words++;
    if (bad_words <= 10) begin
      exp_s = $sformatf("filtered=%0d row=%0d col=%0d last=%0b",
                        exp_w.filtered, exp_w.row, exp_w.col, exp_w.last);
      act_s = $sformatf("filtered=%0d row=%0d col=%0d last=%0b",
                        act_w.filtered, act_w.row, act_w.col, act_w.last);
      $display("%0s at cycle %0d: expected %0s, got %0s", what, cycle_count, exp_s, act_s);
    end
  endtask

  // output side: check each taken word, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = {filtered_o, center_row_o, center_col_o, frame_last_o};
        if (pending_words.size() == 0) begin
          note_bad_word("unexpected word", got, got);
        end else begin
          want = pending_words.pop_front();
          if (got.filtered !== want.filtered || got.row !== want.row ||
              got.col !== want.col || got.last !== want.last)
            note_bad_word("wrong word", want, got);
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        gap_pct = 0;
        stall_pct <= 0;
      end
      IDLE_SENDER: begin
        gap_pct = 49;
        stall_pct <= 0;
      end
      IDLE_RECEIVER: begin
        gap_pct = 0;
        stall_pct <= 49;
      end
      default: begin
        gap_pct = 20;
        stall_pct <= 20;
      end
    endcase
  endtask

  task automatic push_word(input logic [PIX_W-1:0] pix, input logic fs, input bit typed,
                           input out_word_t typed_word);
    out_word_t word;
    bit        hit;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i <= pix;
    frame_start_i <= fs;
    do @(posedge clk_i); while (!in_ready_o);
    hit = window_filter_step(pix, fs, word);
    if (typed) pending_words.push_back(typed_word);
    else if (hit) pending_words.push_back(word);
  endtask

  // never returns before a clock edge, so valid never gets two updates in a step
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_words.size() != 0);
  endtask

  task automatic settle();
    drain_results();
    repeat (PIPE_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_FRAME_WIDTH:   frame_width_q = data;
      REG_FRAME_HEIGHT:  frame_height_q = data;
      REG_MIDRANGE_MODE: midrange_q = data[0];
      default:           wsize_q = data[2:0];
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // a wider frame mid-stream would read columns never stored, so restart then
  task automatic configure_phase(input logic [CFG_W-1:0] w_data, input logic [CFG_W-1:0] h_data,
                                 input logic [CFG_W-1:0] mode_data,
                                 input logic [CFG_W-1:0] ws_data);
    int unsigned old_w;
    settle();
    old_w = clamp_dim(frame_width_q);
    write_reg(REG_FRAME_WIDTH, w_data);
    write_reg(REG_FRAME_HEIGHT, h_data);
    write_reg(REG_MIDRANGE_MODE, mode_data);
    write_reg(REG_WINDOW_SIZE, ws_data);
    need_restart = clamp_dim(frame_width_q) > old_w;
  endtask

  task automatic run_random_phase(input int unsigned n_items, input bit noisy,
                                  input bit hold_off);
    logic [PIX_W-1:0] pix;
    logic             fs;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (hold_off && k == n_items / 2) drain_results();
      fs = (k == 0 && need_restart) ||
           (row_pos == 0 && col_pos == 0 && $urandom_range(0, 3) != 0) ||
           (noisy && $urandom_range(0, 79) == 0);
      case ($urandom_range(0, 7))
        0:       pix = '0;
        1:       pix = PIX_MAX;
        default: pix = PIX_W'($urandom_range(0, 255));
      endcase
      push_word(pix, fs, 1'b0, '0);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] w_data, h_data, mode_data, ws_data;
    stim_row_t        row;

    // directed 5x5 frame: mean, midrange, a bad size, then a 5x5 window
    add_cfg(REG_FRAME_WIDTH, 12'd5);
    add_cfg(REG_FRAME_HEIGHT, 12'd5);
    add_cfg(REG_MIDRANGE_MODE, {11'd0, MODE_MEAN});
    add_cfg(REG_WINDOW_SIZE, {9'd0, WSIZE_3});
    add_px(PIX_MAX, 1'b1);
    for (int k = 1; k < 12; k++) add_px(PIX_MAX, 1'b0);
    add_px_typed(PIX_MAX, 1'b0, PIX_MAX, 11'd1, 11'd1, 1'b0);
    add_cfg(REG_MIDRANGE_MODE, {11'd0, MODE_MID});
    add_px_typed(8'd0, 1'b0, 8'd127, 11'd1, 11'd2, 1'b0);
    add_px_typed(8'd0, 1'b0, 8'd127, 11'd1, 11'd3, 1'b0);
    add_cfg(REG_WINDOW_SIZE, {9'd0, WSIZE_BAD});
    add_px(8'd0, 1'b0);
    add_px(PIX_MAX, 1'b0);
    add_px(8'd128, 1'b0);
    add_px(8'd1, 1'b0);
    add_px(8'd254, 1'b0);
    add_cfg(REG_WINDOW_SIZE, {9'h1FF, WSIZE_5});
    add_cfg(REG_MIDRANGE_MODE, 12'hABC);
    add_px(8'd17, 1'b0);
    add_px(8'd200, 1'b0);
    add_px(8'd3, 1'b0);
    add_px(8'd99, 1'b0);
    add_px(PIX_MAX, 1'b0);

    row_pos = 0;
    col_pos = 0;
    frame_width_q = RST_WIDTH;
    frame_height_q = RST_HEIGHT;
    midrange_q = MODE_MEAN;
    wsize_q = WSIZE_3;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_idling(IDLE_NONE);

    foreach (stim_rows[n]) begin
      row = stim_rows[n];
      if (row.kind == ROW_CFG) begin
        settle();
        write_reg(row.idx, row.data);
      end else begin
        push_word(row.pix, row.fs, row.typed, row.word);
      end
    end

    for (int p = 0; p < 9; p++) begin
      if (p == 0) begin
        w_data = 12'd5;
        h_data = 12'd5;
        mode_data = {11'd0, MODE_MEAN};
        ws_data = {9'd0, WSIZE_3};
      end else begin
        w_data = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 4))
                                             : CFG_W'($urandom_range(5, 12));
        h_data = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 4))
                                             : CFG_W'($urandom_range(5, 9));
        mode_data = CFG_W'($urandom_range(0, 4095));
        ws_data = CFG_W'($urandom_range(0, 4095));
        case ($urandom_range(0, 4))
          0, 1:    ws_data[2:0] = WSIZE_3;
          2, 3:    ws_data[2:0] = WSIZE_5;
          default: ws_data[2:0] = 3'($urandom_range(0, 7));
        endcase
      end
      configure_phase(w_data, h_data, mode_data, ws_data);
      set_idling(idle_mode_e'(p % 4));
      run_random_phase(80, 1'b1, (p % 3) == 1);
    end

    // widest rows clamp to the store depth; the first row stays open, so no word
    configure_phase(12'hFFF, 12'd5, CFG_W'($urandom_range(0, 1)), {9'd0, WSIZE_3});
    set_idling(IDLE_NONE);
    run_random_phase(40, 1'b0, 1'b0);

    // tallest frame, continued from the wide one with narrower rows
    configure_phase(12'd6, 12'hFFF, {11'd0, MODE_MID}, {9'd0, WSIZE_5});
    set_idling(IDLE_BOTH);
    run_random_phase(80, 1'b0, 1'b0);

    settle();
    if (bad_words == 0 && pending_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
